// ===== rtl/mfr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfr_pkg: multidrop frame receiver shared definitions
// Types, codes and constants used by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfr_pkg;

   // Frame markers and register reset values
   localparam logic [7:0] MarkStart       = 8'h02;
   localparam logic [7:0] MarkEnd         = 8'h03;
   localparam logic [7:0] SlaveAddrReset  = 8'h41;
   localparam logic [7:0] GroupAddrReset  = 8'h40;

   // Configuration register select (paddr bit 2)
   localparam logic CsrSlaveAddr = 1'b0;
   localparam logic CsrGroupAddr = 1'b1;

   localparam int CsrAddrWidth = 3;

   // Result kinds
   localparam logic [1:0] KindData   = 2'd0;
   localparam logic [1:0] KindAccept = 2'd1;
   localparam logic [1:0] KindReject = 2'd2;

   // Reject causes
   localparam logic [2:0] CauseNone    = 3'd0;
   localparam logic [2:0] CauseAddr    = 3'd1;
   localparam logic [2:0] CauseLine    = 3'd2;
   localparam logic [2:0] CauseNoStart = 3'd3;
   localparam logic [2:0] CauseNoEnd   = 3'd4;
   localparam logic [2:0] CauseSum     = 3'd5;

   typedef enum logic [6:0] {
      PH_HUNT = 7'b0000001,
      PH_LEN  = 7'b0000010,
      PH_FUNC = 7'b0000100,
      PH_STX  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_ETX  = 7'b0100000,
      PH_SUM  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] slave_address;
      logic [7:0] group_address;
   } addr_cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       address_flag;
      logic       line_error;
   } req_word_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [2:0] reject_cause;
      logic [7:0] function_code;
      logic [7:0] data_value;
      logic [7:0] data_index;
      logic [7:0] frame_length;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/mfr_if.sv =====
// ----------------------------------------------------------------------------
// mfr_if: frame receiver channel interfaces
// Valid/ready channels for received characters and for result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       address_flag;
   logic       line_error;

   modport source (output valid, output rx_byte, output address_flag,
                   output line_error, input ready);
   modport sink   (input valid, input rx_byte, input address_flag,
                   input line_error, output ready);
endinterface

interface mfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [2:0] reject_cause;
   logic [7:0] function_code;
   logic [7:0] data_value;
   logic [7:0] data_index;
   logic [7:0] frame_length;

   modport source (output valid, output result_kind, output reject_cause,
                   output function_code, output data_value, output data_index,
                   output frame_length, input ready);
   modport sink   (input valid, input result_kind, input reject_cause,
                   input function_code, input data_value, input data_index,
                   input frame_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/mfr_csr.sv =====
// ----------------------------------------------------------------------------
// mfr_csr: configuration registers
// APB-style register file holding the slave and group addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module mfr_csr
   import mfr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]             pwdata,
   output      logic [31:0]             prdata,
   output      logic                    pready,
   output      addr_cfg_type            addr_cfg
);

   addr_cfg_type cfg_ff, cfg_in;
   logic         wr_en;
   logic         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];   // low address bits are not decoded

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            CsrSlaveAddr: cfg_in.slave_address = pwdata[7:0];
            CsrGroupAddr: cfg_in.group_address = pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= SlaveAddrReset;
         cfg_ff.group_address <= GroupAddrReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         CsrSlaveAddr: prdata = {24'd0, cfg_ff.slave_address};
         CsrGroupAddr: prdata = {24'd0, cfg_ff.group_address};
         default:      prdata = 32'd0;
      endcase
   end

   assign addr_cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/mfr_parser.sv =====
// ----------------------------------------------------------------------------
// mfr_parser: frame parse state machine
// Holds the frame state and decides the result for one character per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mfr_parser
   import mfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type word,
   input  wire addr_cfg_type addr_cfg,
   output      logic         has_result,
   output      rsp_word_type result
);

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] seen_inc;
   logic       addr_match;

   assign seen_inc   = seen_ff + 8'd1;
   assign addr_match = (word.rx_byte == addr_cfg.slave_address) ||
                       (word.rx_byte == addr_cfg.group_address);

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      func_in    = func_ff;
      sum_in     = sum_ff;
      has_result = 1'b0;
      result.result_kind   = KindReject;
      result.reject_cause  = CauseNone;
      result.function_code = func_ff;
      result.data_value    = 8'd0;
      result.data_index    = 8'd0;
      result.frame_length  = length_ff;

      if (phase_ff == PH_HUNT) begin
         if (!word.line_error && word.address_flag && addr_match) begin
            phase_in  = PH_LEN;
            length_in = 8'd0;
            seen_in   = 8'd0;
            func_in   = 8'd0;
            sum_in    = 8'd0;
         end
      end else if (word.line_error) begin
         has_result          = 1'b1;
         result.reject_cause = CauseLine;
         phase_in            = PH_HUNT;
      end else if (word.address_flag) begin
         has_result          = 1'b1;
         result.reject_cause = CauseAddr;
         phase_in            = PH_HUNT;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               length_in = word.rx_byte;
               phase_in  = PH_FUNC;
            end
            PH_FUNC: begin
               func_in  = word.rx_byte;
               sum_in   = word.rx_byte;
               phase_in = PH_STX;
            end
            PH_STX: begin
               if (word.rx_byte != MarkStart) begin
                  has_result          = 1'b1;
                  result.reject_cause = CauseNoStart;
                  phase_in            = PH_HUNT;
               end else begin
                  sum_in   = sum_ff + MarkStart;
                  seen_in  = 8'd0;
                  phase_in = (length_ff == 8'd0) ? PH_ETX : PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in  = sum_ff + word.rx_byte;
               seen_in = seen_inc;
               if (seen_inc >= length_ff) begin
                  phase_in = PH_ETX;
               end
               has_result         = 1'b1;
               result.result_kind = KindData;
               result.data_value  = word.rx_byte;
               result.data_index  = seen_ff;
            end
            PH_ETX: begin
               if (word.rx_byte != MarkEnd) begin
                  has_result          = 1'b1;
                  result.reject_cause = CauseNoEnd;
                  phase_in            = PH_HUNT;
               end else begin
                  sum_in   = sum_ff + MarkEnd;
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               has_result = 1'b1;
               phase_in   = PH_HUNT;
               if (word.rx_byte != sum_ff) begin
                  result.reject_cause = CauseSum;
               end else begin
                  result.result_kind = KindAccept;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= 8'd0;
         seen_ff   <= 8'd0;
         func_ff   <= 8'd0;
         sum_ff    <= 8'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         func_ff   <= func_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/multidrop_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// multidrop_frame_receiver_core: nine-bit address mode frame receiver
// Hunts for its station or group address, parses length, function, start
// marker, payload, end marker and checksum, and reports each payload byte
// plus one accept or reject word per frame.
//
// Channels: req_chan takes one received character per word (byte, ninth
// address bit, line error); rsp_chan gives zero or one result word per
// character. Both are valid/ready; a word moves when valid and ready are
// both high. Registers sit on the APB port: slave address at 0x0, group
// address at 0x4.
//
// Path: a character is held in the input register, is parsed and its
// result lands in the output register, from which the result word is
// offered. Throughput is one character per cycle while the result side
// does not stall, set by the combinational parse between the two registers.
//
// Reset clears both registers' valid flags, puts the parser in hunting and
// restores the address registers to 0x41 and 0x40. When the result side
// stalls, the held character waits in the input register and req ready
// drops only once both registers are full and the result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multidrop_frame_receiver_core
   import mfr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   mfr_req_if.sink                      req_chan,
   mfr_rsp_if.source                    rsp_chan,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]             pwdata,
   output      logic [31:0]             prdata,
   output      logic                    pready
);

   addr_cfg_type addr_cfg;

   // input register
   logic         in_valid_ff;
   req_word_type in_word_ff;
   // output register
   logic         out_valid_ff;
   rsp_word_type out_word_ff;

   logic         step;
   logic         req_take;
   logic         has_result;
   rsp_word_type result;

   mfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .addr_cfg (addr_cfg)
   );

   // A held character is parsed once the output register is free or draining.
   assign step     = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_take = req_chan.valid & req_chan.ready;

   assign req_chan.ready = ~in_valid_ff | step;

   mfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .word       (in_word_ff),
      .addr_cfg   (addr_cfg),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.rx_byte      <= req_chan.rx_byte;
         in_word_ff.address_flag <= req_chan.address_flag;
         in_word_ff.line_error   <= req_chan.line_error;
      end
   end

   // Characters with no result still advance; they just leave the output alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_result) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_word_ff.result_kind;
   assign rsp_chan.reject_cause  = out_word_ff.reject_cause;
   assign rsp_chan.function_code = out_word_ff.function_code;
   assign rsp_chan.data_value    = out_word_ff.data_value;
   assign rsp_chan.data_index    = out_word_ff.data_index;
   assign rsp_chan.frame_length  = out_word_ff.frame_length;

endmodule

`default_nettype wire
